// ----- hdl/tlos_pkg.sv -----
// Package for the tile line-of-sight block: widths, defaults and shared types.
// No dependencies.
package tlos_pkg;
   localparam int MapWidthDefault  = 64;
   localparam int MapHeightDefault = 64;
   localparam int CoordBitsDefault = 13;
   localparam int TsBits           = 6;
   localparam logic [TsBits-1:0] TileSizeReset = 6'd16;
   localparam int TileFieldBits    = 6;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;
endpackage

// ----- hdl/tlos_if.sv -----
// Valid/ready channel interfaces for the tile line-of-sight block.
// Depends on tlos_pkg.
interface tlos_req_if #(parameter int COORD_BITS = tlos_pkg::CoordBitsDefault) ();
   logic                                  valid;
   logic                                  ready;
   logic                                  kind;
   logic [tlos_pkg::TileFieldBits-1:0]    tile_col;
   logic [tlos_pkg::TileFieldBits-1:0]    tile_row;
   logic                                  tile_solid;
   logic signed [COORD_BITS-1:0]          from_x;
   logic signed [COORD_BITS-1:0]          from_y;
   logic signed [COORD_BITS-1:0]          to_x;
   logic signed [COORD_BITS-1:0]          to_y;
   modport source (output valid, kind, tile_col, tile_row, tile_solid,
                   from_x, from_y, to_x, to_y, input ready);
   modport sink (input valid, kind, tile_col, tile_row, tile_solid,
                 from_x, from_y, to_x, to_y, output ready);
endinterface

interface tlos_rsp_if ();
   logic valid;
   logic ready;
   logic clear;
   modport source (output valid, clear, input ready);
   modport sink (input valid, clear, output ready);
endinterface

// ----- hdl/tlos_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependencies.
module tlos_divider #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);
   localparam int CntBits = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]   quo_ff, quo_in;
   logic [WIDTH-1:0]   rem_ff, rem_in;
   logic [WIDTH-1:0]   dsr_ff, dsr_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [WIDTH:0]     trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[WIDTH-1]} - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CntBits'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract when it fits
         if (!trial[WIDTH]) begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WIDTH-2:0], quo_ff[WIDTH-1]};
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");
   a_no_busy_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");
   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with empty count");
endmodule

// ----- hdl/tlos_map_mem.sv -----
// Solid tile map: one-bit synchronous memory with a sweep-based clear after reset.
// No package dependencies.
module tlos_map_mem #(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic                     wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic                     rd_data,
   output logic                     init_done
);
   localparam int AddrBits = $clog2(DEPTH);

   logic                mem [DEPTH];
   logic                rd_ff;
   logic [AddrBits-1:0] sweep_ff, sweep_in;
   logic                init_ff, init_in;
   logic                we;
   logic [AddrBits-1:0] wa;
   logic                wd;

   always_comb begin
      sweep_in = sweep_ff;
      init_in  = init_ff;
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
      if (!init_ff) begin
         // clear one entry per cycle until the whole map reads not solid
         we = 1'b1;
         wa = sweep_ff;
         wd = 1'b0;
         sweep_in = sweep_ff + 1'b1;
         if (sweep_ff == AddrBits'(DEPTH - 1)) begin
            init_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         init_ff  <= 1'b0;
      end else begin
         sweep_ff <= sweep_in;
         init_ff  <= init_in;
      end
   end

   assign rd_data   = rd_ff;
   assign init_done = init_ff;

   a_init_stays: assert property (@(posedge clock) disable iff (reset)
      init_ff |=> init_ff)
      else $error("map init flag dropped");
   a_sweep_order: assert property (@(posedge clock) disable iff (reset)
      !init_ff && !$past(reset) && $past(!init_ff) |-> sweep_ff == $past(sweep_ff) + 1'b1)
      else $error("map clear sweep skipped an entry");
   a_init_end: assert property (@(posedge clock) disable iff (reset)
      $rose(init_ff) |-> $past(sweep_ff) == AddrBits'(DEPTH - 1))
      else $error("map clear ended early");
endmodule

// ----- hdl/tile_line_of_sight.sv -----
// Top level of the tile line-of-sight block: query sequencer around the tile map.
// Depends on tlos_pkg, tlos_if, tlos_divider and tlos_map_mem.
//
// Usage: words arrive on req (valid/ready). A write word (kind 0) sets one
// tile's solid bit in the map and gives no rsp word. A query word (kind 1)
// carries two pixel points and gives one rsp word whose clear bit is 1 when
// no intermediate sampled tile is solid. csr_we/csr_wdata load tile_size;
// write it only while the block is idle.
// Flow: a write lands in the map at the edge that accepts it.
// Every division goes through one shared bit-serial divider of
// 2*COORD_BITS+2 bits that raises done after its last quotient bit. A
// query is accepted in idle, then runs five divisions of setup (four
// endpoint tiles and the step count), then per sample four divisions (two
// offsets, two tiles) plus a map read and a check, then loads rsp.
// A tile size of zero skips the divisions and answers clear from the done
// state; fewer than two steps answers right after setup. The next word is
// taken once the sequencer is back in idle.
// Reset: the map is cleared by a sweep over all MAP_WIDTH*MAP_HEIGHT entries,
// one entry a cycle, during which req.ready stays low; tile_size returns to 16.
// Stall: a finished rsp word is held in an output register; the block keeps
// taking words meanwhile, and a following query holds in its final state
// until the register is free.
module tile_line_of_sight #(
   parameter int MAP_WIDTH  = tlos_pkg::MapWidthDefault,
   parameter int MAP_HEIGHT = tlos_pkg::MapHeightDefault,
   parameter int COORD_BITS = tlos_pkg::CoordBitsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   tlos_req_if.sink                          req,
   tlos_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [tlos_pkg::TsBits-1:0]       csr_wdata
);
   localparam int Depth   = MAP_WIDTH * MAP_HEIGHT;
   localparam int AddrBits = $clog2(Depth);
   localparam int ColBits = $clog2(MAP_WIDTH);
   localparam int RowBits = $clog2(MAP_HEIGHT);
   // differences need one more bit, products by i need the magnitude twice
   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_TDIV  = 10'b0000000010,
      S_TWAIT = 10'b0000000100,
      S_SDIV  = 10'b0000001000,
      S_SWAIT = 10'b0000010000,
      S_PDIV  = 10'b0000100000,
      S_PWAIT = 10'b0001000000,
      S_READ  = 10'b0010000000,
      S_CHECK = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [tlos_pkg::TsBits-1:0] ts_ff, ts_in;
   logic signed [DW-1:0] fx_ff, fy_ff, tx_ff, ty_ff;
   logic signed [DW-1:0] fx_in, fy_in, tx_in, ty_in;
   logic signed [DW-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [DW-1:0] ftx_ff, fty_ff, ttx_ff, tty_ff;
   logic signed [DW-1:0] ftx_in, fty_in, ttx_in, tty_in;
   logic signed [DW-1:0] sx_ff, sy_ff, sx_in, sy_in;
   logic [DW-1:0] steps_ff, steps_in;
   logic [DW-1:0] i_ff, i_in;
   logic [2:0]    sel_ff, sel_in;     // which division is in flight
   logic          clear_ff, clear_in;
   logic          out_clear_ff, out_clear_in;
   logic          rv_ff, rv_in;

   // shared divider
   logic          div_start;
   logic [PW-1:0] div_a, div_b, div_q, div_r;
   logic          div_done;

   // map
   logic                map_we;
   logic [AddrBits-1:0] map_wa, map_ra;
   logic                map_rd, map_init;

   logic signed [DW-1:0] op_val;
   logic                 op_neg;
   logic [DW-1:0]        op_mag;
   logic signed [DW-1:0] floor_res;
   logic signed [PW-1:0] trunc_res;
   logic signed [DW-1:0] samp_pt;
   logic [DW-1:0]        adx, ady, span;
   logic [DW-1:0]        stride;
   logic [PW-1:0]        prod_mag;
   logic                 prod_neg;
   logic                 swap;
   logic signed [DW-1:0] ax, ay, bx, by;
   logic                 in_map, endpoint_hit;

   tlos_divider #(.WIDTH(PW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q),
      .remainder(div_r)
   );

   tlos_map_mem #(.DEPTH(Depth)) u_map (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (map_we),
      .wr_addr  (map_wa),
      .wr_data  (req.tile_solid),
      .rd_addr  (map_ra),
      .rd_data  (map_rd),
      .init_done(map_init)
   );

   assign req.ready = map_init && (state_ff == S_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.clear = out_clear_ff;

   // write port: drop writes outside the map
   always_comb begin
      map_we = req.valid && req.ready && (req.kind == tlos_pkg::KIND_WRITE) &&
               ({3'b0, req.tile_col} < 9'(MAP_WIDTH)) &&
               ({3'b0, req.tile_row} < 9'(MAP_HEIGHT));
      map_wa = AddrBits'(({2'b0, req.tile_row} * MAP_WIDTH) + {2'b0, req.tile_col});
   end

   // canonical order of endpoints
   always_comb begin
      ax = DW'(req.from_x);
      ay = DW'(req.from_y);
      bx = DW'(req.to_x);
      by = DW'(req.to_y);
      swap = (by < ay) || ((by == ay) && (bx < ax));
   end

   assign adx  = dx_ff[DW-1] ? DW'(-dx_ff) : dx_ff;
   assign ady  = dy_ff[DW-1] ? DW'(-dy_ff) : dy_ff;
   assign span = (adx > ady) ? adx : ady;
   assign stride = (ts_ff[tlos_pkg::TsBits-1:1] != '0) ?
                   DW'(ts_ff[tlos_pkg::TsBits-1:1]) : DW'(1);

   // operand of the current floor division by tile size
   always_comb begin
      unique case (sel_ff)
         3'd0:    op_val = fx_ff;
         3'd1:    op_val = fy_ff;
         3'd2:    op_val = tx_ff;
         3'd3:    op_val = ty_ff;
         3'd4:    op_val = sx_ff;
         default: op_val = sy_ff;
      endcase
      op_neg = op_val[DW-1];
      op_mag = op_neg ? DW'(-op_val) : op_val;
      // floor: negate, then subtract one if there is a remainder
      if (op_neg) begin
         floor_res = DW'(-$signed(div_q[DW-1:0])) - ((div_r != '0) ? DW'(1) : DW'(0));
      end else begin
         floor_res = $signed(div_q[DW-1:0]);
      end
   end

   // sample offset d*i (sign-magnitude), truncating divide by steps
   always_comb begin
      if (sel_ff[0]) begin
         prod_neg = dy_ff[DW-1];
         prod_mag = PW'(ady) * PW'(i_ff);
      end else begin
         prod_neg = dx_ff[DW-1];
         prod_mag = PW'(adx) * PW'(i_ff);
      end
      trunc_res = prod_neg ? PW'(-$signed(div_q)) : $signed(div_q);
      samp_pt = sel_ff[0] ? DW'(fy_ff + DW'(trunc_res)) : DW'(fx_ff + DW'(trunc_res));
   end

   assign in_map = !sx_ff[DW-1] && !sy_ff[DW-1] &&
                   (sx_ff < DW'(MAP_WIDTH)) && (sy_ff < DW'(MAP_HEIGHT));
   assign endpoint_hit = ((sx_ff == ftx_ff) && (sy_ff == fty_ff)) ||
                         ((sx_ff == ttx_ff) && (sy_ff == tty_ff));
   assign map_ra = AddrBits'((PW'(sy_ff[RowBits-1:0]) * MAP_WIDTH) +
                             PW'(sx_ff[ColBits-1:0]));

   always_comb begin
      state_in = state_ff;
      ts_in = csr_we ? csr_wdata : ts_ff;
      fx_in = fx_ff; fy_in = fy_ff; tx_in = tx_ff; ty_in = ty_ff;
      dx_in = dx_ff; dy_in = dy_ff;
      ftx_in = ftx_ff; fty_in = fty_ff; ttx_in = ttx_ff; tty_in = tty_ff;
      sx_in = sx_ff; sy_in = sy_ff;
      steps_in = steps_ff;
      i_in = i_ff;
      sel_in = sel_ff;
      clear_in = clear_ff;
      out_clear_in = out_clear_ff;
      rv_in = rv_ff && !rsp.ready;
      div_start = 1'b0;
      div_a = PW'(op_mag);
      div_b = PW'(ts_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready && (req.kind == tlos_pkg::KIND_QUERY)) begin
               fx_in = swap ? bx : ax;
               fy_in = swap ? by : ay;
               tx_in = swap ? ax : bx;
               ty_in = swap ? ay : by;
               dx_in = swap ? DW'(ax - bx) : DW'(bx - ax);
               dy_in = swap ? DW'(ay - by) : DW'(by - ay);
               sel_in = 3'd0;
               clear_in = 1'b1;
               state_in = (ts_ff == '0) ? S_DONE : S_TDIV;
            end
         end
         S_TDIV: begin
            div_start = 1'b1;
            state_in = S_TWAIT;
         end
         S_TWAIT: begin
            if (div_done) begin
               unique case (sel_ff)
                  3'd0:    ftx_in = floor_res;
                  3'd1:    fty_in = floor_res;
                  3'd2:    ttx_in = floor_res;
                  default: tty_in = floor_res;
               endcase
               if (sel_ff == 3'd3) begin
                  state_in = S_SDIV;
               end else begin
                  sel_in = sel_ff + 1'b1;
                  state_in = S_TDIV;
               end
            end
         end
         S_SDIV: begin
            div_start = 1'b1;
            div_a = PW'(span);
            div_b = PW'(stride);
            state_in = S_SWAIT;
         end
         S_SWAIT: begin
            if (div_done) begin
               steps_in = div_q[DW-1:0];
               i_in = DW'(1);
               sel_in = 3'd0;
               state_in = (div_q < PW'(2)) ? S_DONE : S_PDIV;
            end
         end
         S_PDIV: begin
            // sel 0/1: sample offsets; sel 4/5: tile divides of sample
            div_start = 1'b1;
            if (sel_ff[2]) begin
               div_a = PW'(op_mag);
               div_b = PW'(ts_ff);
            end else begin
               div_a = prod_mag;
               div_b = PW'(steps_ff);
            end
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            if (div_done) begin
               unique case (sel_ff)
                  3'd0:    begin sx_in = samp_pt;   sel_in = 3'd1; state_in = S_PDIV; end
                  3'd1:    begin sy_in = samp_pt;   sel_in = 3'd4; state_in = S_PDIV; end
                  3'd4:    begin sx_in = floor_res; sel_in = 3'd5; state_in = S_PDIV; end
                  default: begin sy_in = floor_res; sel_in = 3'd0; state_in = S_READ; end
               endcase
            end
         end
         S_READ: begin
            // map read address is registered inside the memory this cycle
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!endpoint_hit && in_map && map_rd) begin
               clear_in = 1'b0;
               state_in = S_DONE;
            end else if (i_ff + 1'b1 >= steps_ff) begin
               state_in = S_DONE;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_PDIV;
            end
         end
         S_DONE: begin
            // hold here until the output register is free
            if (!rv_ff) begin
               rv_in = 1'b1;
               out_clear_in = clear_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      fx_ff <= fx_in; fy_ff <= fy_in; tx_ff <= tx_in; ty_ff <= ty_in;
      dx_ff <= dx_in; dy_ff <= dy_in;
      ftx_ff <= ftx_in; fty_ff <= fty_in; ttx_ff <= ttx_in; tty_ff <= tty_in;
      sx_ff <= sx_in; sy_ff <= sy_in;
      steps_ff <= steps_in;
      i_ff <= i_in;
      sel_ff <= sel_in;
      clear_ff <= clear_in;
      out_clear_ff <= out_clear_in;
      if (reset) begin
         state_ff <= S_IDLE;
         ts_ff    <= tlos_pkg::TileSizeReset;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ts_ff    <= ts_in;
         rv_ff    <= rv_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp.ready |=> rv_ff && $stable(out_clear_ff))
      else $error("response dropped while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req.ready)
      else $error("request accepted during a query");
   a_ready_init: assert property (@(posedge clock) disable iff (reset)
      !map_init |-> !req.ready)
      else $error("request accepted during map clear");
   a_zero_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && req.valid && req.ready && req.kind && ts_ff == '0
      |=> state_ff == S_DONE && clear_ff)
      else $error("zero tile size did not answer clear");
endmodule

// ----- tb/sv/tb_tile_line_of_sight.sv -----
// Self-checking bench for tile_line_of_sight: drives map writes and line-of-sight
// queries, predicts each clear bit with a local map model, and checks rsp words.
// Depends on tlos_pkg, tlos_if and the tile_line_of_sight RTL.
module tb_tile_line_of_sight;
   localparam int MAP_W      = 64;
   localparam int MAP_H      = 64;
   localparam int CB         = 13;
   localparam int CYCLE_CAP  = 40_000_000;
   localparam int TAIL_WAIT  = 400;     // covers a write plus a query setup
   localparam int MAX_REPORT = 10;
   localparam int LONG_HOLD  = 20_000;  // outlasts two of the longest backpressure-test queries

   typedef struct {
      tlos_pkg::kind_type   kind;
      logic [5:0]           col;
      logic [5:0]           row;
      logic                 solid;
      logic signed [CB-1:0] fx;
      logic signed [CB-1:0] fy;
      logic signed [CB-1:0] tx;
      logic signed [CB-1:0] ty;
   } los_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [tlos_pkg::TsBits-1:0] csr_wdata = '0;

   tlos_req_if #(.COORD_BITS(CB)) req_if ();
   tlos_rsp_if                    rsp_if ();

   tile_line_of_sight #(.MAP_WIDTH(MAP_W), .MAP_HEIGHT(MAP_H), .COORD_BITS(CB)) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // local copy of the block state
   bit          solid_tiles [MAP_W*MAP_H];
   int unsigned tile_px = tlos_pkg::TileSizeReset;
   bit          clear_q [$];      // expected clear bits, oldest first

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit long_hold_req  = 1'b0;
   int hold_left      = 0;
   int mismatches     = 0;
   int cycles         = 0;

   function automatic longint floor_tile(longint v, longint d);
      longint q;
      q = v / d;
      if ((v % d) != 0 && ((v < 0) != (d < 0))) q = q - 1;
      return q;
   endfunction

   function automatic bit tile_blocks(longint cx, longint cy);
      if (cx < 0 || cy < 0 || cx >= MAP_W || cy >= MAP_H) return 1'b0;
      return solid_tiles[cy*MAP_W + cx];
   endfunction

   // walk the sampled points and report whether any intermediate tile is solid
   function automatic bit sight_clear(los_word_type w);
      longint ts, ax, ay, bx, by, t, atx, aty, btx, bty, dx, dy, span, stride, steps;
      longint sx, sy;
      ts = tile_px;
      if (ts <= 0) return 1'b1;
      ax = w.fx; ay = w.fy; bx = w.tx; by = w.ty;
      if (by < ay || (by == ay && bx < ax)) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
      end
      atx = floor_tile(ax, ts); aty = floor_tile(ay, ts);
      btx = floor_tile(bx, ts); bty = floor_tile(by, ts);
      dx = bx - ax;
      dy = by - ay;
      span = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) ? (dx < 0 ? -dx : dx)
                                                         : (dy < 0 ? -dy : dy);
      stride = (ts / 2 > 0) ? ts / 2 : 1;
      steps = span / stride;
      for (longint i = 1; i < steps; i++) begin
         sx = floor_tile(ax + (dx * i) / steps, ts);
         sy = floor_tile(ay + (dy * i) / steps, ts);
         if ((sx == atx && sy == aty) || (sx == btx && sy == bty)) continue;
         if (tile_blocks(sx, sy)) return 1'b0;
      end
      return 1'b1;
   endfunction

   // advance the local state for one accepted word
   function automatic void predict_word(los_word_type w);
      if (w.kind == tlos_pkg::KIND_WRITE) begin
         solid_tiles[w.row*MAP_W + w.col] = w.solid;
      end else begin
         clear_q.push_back(sight_clear(w));
      end
   endfunction

   // ---------------------------------------------------------------------
   // Sender: hold valid across back-to-back words, drop it only for gaps.
   // ---------------------------------------------------------------------
   task automatic send_word(los_word_type w);
      int gap;
      @(negedge clock);
      gap = 0;
      if (send_idle_pct > 0)
         while ($urandom_range(99) < send_idle_pct && gap < 12) gap++;
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.kind       = w.kind;
      req_if.tile_col   = w.col;
      req_if.tile_row   = w.row;
      req_if.tile_solid = w.solid;
      req_if.from_x     = w.fx;
      req_if.from_y     = w.fy;
      req_if.to_x       = w.tx;
      req_if.to_y       = w.ty;
      req_if.valid      = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      predict_word(w);
   endtask

   task automatic write_tile(int col, int row, bit solid);
      los_word_type w;
      w = '{tlos_pkg::KIND_WRITE, col[5:0], row[5:0], solid, '0, '0, '0, '0};
      send_word(w);
   endtask

   task automatic ask_sight(int fx, int fy, int tx, int ty);
      los_word_type w;
      w = '{tlos_pkg::KIND_QUERY, 6'($urandom_range(63)), 6'($urandom_range(63)),
            1'($urandom_range(1)), fx[CB-1:0], fy[CB-1:0], tx[CB-1:0], ty[CB-1:0]};
      send_word(w);
   endtask

   // wait until every query has answered, then let a trailing write settle
   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (clear_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_tile_size(int value);
      drain();
      csr_we    = 1'b1;
      csr_wdata = value[tlos_pkg::TsBits-1:0];
      @(negedge clock);
      csr_we    = 1'b0;
      tile_px   = value;
   endtask

   function automatic int clamp_coord(int v);
      if (v < -4096) return -4096;
      if (v > 4095) return 4095;
      return v;
   endfunction

   // Random word: writes mostly land in a 16x16 corner so that lines meet them;
   // queries start in or near that corner and span a bounded count of steps.
   task automatic random_word();
      int ts, stride, cap, span, fx, fy, dx, dy;
      ts = tile_px;
      if ($urandom_range(99) < 40) begin
         if ($urandom_range(99) < 80)
            write_tile($urandom_range(15), $urandom_range(15), $urandom_range(99) < 65);
         else
            write_tile($urandom_range(63), $urandom_range(63), $urandom_range(1));
         return;
      end
      if (ts == 0) begin
         ask_sight($urandom, $urandom, $urandom, $urandom);
         return;
      end
      stride = (ts / 2 > 0) ? ts / 2 : 1;
      cap    = ($urandom_range(19) == 0) ? 64 : 20;
      span   = $urandom_range(cap * stride + stride);
      fx = int'($urandom_range(20 * ts)) - 2 * ts;
      fy = int'($urandom_range(20 * ts)) - 2 * ts;
      dx = int'($urandom_range(2 * span)) - span;
      dy = int'($urandom_range(2 * span)) - span;
      if ($urandom_range(1)) dx = $urandom_range(1) ? span : -span;
      else                   dy = $urandom_range(1) ? span : -span;
      ask_sight(clamp_coord(fx), clamp_coord(fy),
                clamp_coord(fx + dx), clamp_coord(fy + dy));
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off counted here on request.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (long_hold_req) begin
         hold_left     = LONG_HOLD;
         long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready = 1'b0;
      end else begin
         rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check each accepted rsp word against the oldest expected clear bit.
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (clear_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
               $display("rsp word with no query pending: clear=%0b", rsp_if.clear);
         end else begin
            want = clear_q.pop_front();
            if (rsp_if.clear !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORT)
                  $display("clear mismatch: expected %0b actual %0b (tile size %0d)",
                           want, rsp_if.clear, tile_px);
            end
         end
      end
   end

   // Bound the run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_map_and_lines();
      ask_sight(0, 0, 0, 0);                // empty map, zero length
      write_tile(5, 5, 1'b1);
      ask_sight(40, 88, 136, 88);           // crosses the solid tile
      ask_sight(136, 88, 40, 88);           // same line reversed
      ask_sight(200, 88, 88, 88);           // solid tile is an endpoint: skipped
      ask_sight(88, 40, 88, 136);           // vertical through it
      write_tile(0, 0, 1'b1);
      write_tile(63, 63, 1'b1);
      write_tile(63, 0, 1'b1);
      write_tile(0, 63, 1'b1);
      ask_sight(-100, -100, 30, 30);        // negative tiles count as open
      ask_sight(1000, 1000, 1100, 1100);    // runs past the map edge
      write_tile(63, 63, 1'b0);
      ask_sight(1000, 1000, 1100, 1100);
      ask_sight(0, 0, 7, 0);                // fewer than two steps
      ask_sight(60, 200, 10, 200);          // equal y, x out of order
      ask_sight(-4096, -4096, 4095, 4095);  // coordinate extremes
      ask_sight(4095, -4096, -4096, 4095);
      write_tile(5, 5, 1'b0);
      ask_sight(40, 88, 136, 88);
   endtask

   task automatic test_tile_sizes();
      int sizes [5] = '{0, 1, 2, 32, 63};
      foreach (sizes[k]) begin
         set_tile_size(sizes[k]);
         if (sizes[k] == 0) begin
            ask_sight(-4096, -4096, 4095, 4095);
            ask_sight(4095, 4095, -4096, -4096);
         end
         repeat (6) random_word();
      end
   endtask

   task automatic test_random_mix();
      int sizes [8] = '{16, 1, 32, 0, 7, 2, 25, 63};
      int idle_mode [4][2] = '{'{0, 0}, '{53, 0}, '{0, 53}, '{11, 11}};
      foreach (sizes[k]) begin
         set_tile_size(sizes[k]);
         for (int m = 0; m < 4; m++) begin
            send_idle_pct  = idle_mode[(m + k) % 4][0];
            recv_stall_pct = idle_mode[(m + k) % 4][1];
            repeat (37) random_word();
         end
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   // hold rsp off long enough that the block backs up and stalls req
   task automatic test_backpressure();
      set_tile_size(8);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      long_hold_req  = 1'b1;
      repeat (20) ask_sight($urandom_range(120), $urandom_range(120),
                            $urandom_range(120), $urandom_range(120));
      drain();
      repeat (10) random_word();
   endtask

   initial begin
      req_if.valid      = 1'b0;
      req_if.kind       = tlos_pkg::KIND_WRITE;
      req_if.tile_col   = '0;
      req_if.tile_row   = '0;
      req_if.tile_solid = 1'b0;
      req_if.from_x     = '0;
      req_if.from_y     = '0;
      req_if.to_x       = '0;
      req_if.to_y       = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_map_and_lines();
      test_tile_sizes();
      test_backpressure();
      test_random_mix();

      drain();
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatches == 0 && clear_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
